[rtl/core/mi3_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_pkg
// Types and constants shared by the 3x3 matrix inverse pipeline.
// ----------------------------------------------------------------------------
package mi3_pkg;

    localparam int unsigned ENTRY_W   = 32;
    localparam int unsigned PROD_W    = 64;
    localparam int unsigned LO_W      = 65;
    localparam int unsigned TERM_W    = 96;
    localparam int unsigned DET_W     = 97;
    localparam int unsigned MAG_W     = 96;
    localparam int unsigned QUO_W     = 33;
    localparam int unsigned DIV_STEPS = 33;

    localparam logic [31:0]        LIMIT_RESET = 32'd281474977;
    localparam logic signed [31:0] Q16_ONE     = 32'sh0001_0000;
    localparam logic signed [31:0] Q16_ZERO    = 32'sh0000_0000;
    localparam logic signed [31:0] Q16_MAX     = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] Q16_MIN     = 32'sh8000_0000;
    localparam logic [QUO_W-1:0]   QUO_NEG_MAX = 33'h0_8000_0000;

    typedef logic signed [ENTRY_W-1:0] entry_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic [3:0]                idx_t;

    // Cofactor k is m[a]*m[b] - m[c]*m[d], listed as {a, b, c, d}.
    localparam idx_t COF_IDX [9][4] = '{
        '{4'd4, 4'd8, 4'd5, 4'd7},
        '{4'd2, 4'd7, 4'd1, 4'd8},
        '{4'd1, 4'd5, 4'd2, 4'd4},
        '{4'd5, 4'd6, 4'd3, 4'd8},
        '{4'd0, 4'd8, 4'd2, 4'd6},
        '{4'd2, 4'd3, 4'd0, 4'd5},
        '{4'd3, 4'd7, 4'd4, 4'd6},
        '{4'd1, 4'd6, 4'd0, 4'd7},
        '{4'd0, 4'd4, 4'd1, 4'd3}
    };

    typedef struct packed {
        logic [MAG_W-1:0] dmag;
        logic             singular;
    } div_ctl_t;

    typedef struct packed {
        logic [MAG_W-1:0] rem;
        logic [QUO_W-1:0] quo;
        logic             bit_in;
        logic             neg;
        logic             ovf;
    } div_lane_t;

endpackage

[rtl/core/mi3_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3 channel interfaces
// Valid/ready channels for the matrix, the inverse and the limit register.
// ----------------------------------------------------------------------------
interface mi3_in_if;
    import mi3_pkg::*;
    logic   valid;
    logic   ready;
    entry_t m00, m01, m02, m10, m11, m12, m20, m21, m22;
    modport source (output valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                    input ready);
    modport sink (input valid, m00, m01, m02, m10, m11, m12, m20, m21, m22,
                  output ready);
endinterface

interface mi3_out_if;
    import mi3_pkg::*;
    logic   valid;
    logic   ready;
    entry_t inv00, inv01, inv02, inv10, inv11, inv12, inv20, inv21, inv22;
    logic   singular;
    logic   saturated;
    modport source (output valid, inv00, inv01, inv02, inv10, inv11, inv12,
                    inv20, inv21, inv22, singular, saturated, input ready);
    modport sink (input valid, inv00, inv01, inv02, inv10, inv11, inv12,
                  inv20, inv21, inv22, singular, saturated, output ready);
endinterface

interface mi3_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, data, input ready);
    modport sink (input valid, data, output ready);
endinterface

[rtl/core/mi3_cof.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_cof
// Two stages: the eighteen 2x2 minor products, then the nine cofactors.
// ----------------------------------------------------------------------------
module mi3_cof (
    input  logic            clk,
    input  logic            rst_n,
    mi3_in_if.sink          mat_in,
    output logic            valid_out,
    input  logic            ready_in,
    output mi3_pkg::prod_t  cof [9],
    output mi3_pkg::entry_t row0 [3]
);
    import mi3_pkg::*;

    entry_t m [9];
    logic   v1_reg, v2_reg, adv1, adv2;
    prod_t  p_reg [18];
    entry_t r1_reg [3];
    prod_t  cof_reg [9];
    entry_t r2_reg [3];

    assign m[0] = mat_in.m00;
    assign m[1] = mat_in.m01;
    assign m[2] = mat_in.m02;
    assign m[3] = mat_in.m10;
    assign m[4] = mat_in.m11;
    assign m[5] = mat_in.m12;
    assign m[6] = mat_in.m20;
    assign m[7] = mat_in.m21;
    assign m[8] = mat_in.m22;

    assign adv2         = !v2_reg || ready_in;
    assign adv1         = !v1_reg || adv2;
    assign mat_in.ready = adv1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (adv1)
            begin
                v1_reg <= mat_in.valid;
            end
            if (adv2)
            begin
                v2_reg <= v1_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv1 && mat_in.valid)
        begin
            for (int k = 0; k < 9; k++)
            begin
                p_reg[2*k]   <= m[COF_IDX[k][0]] * m[COF_IDX[k][1]];
                p_reg[2*k+1] <= m[COF_IDX[k][2]] * m[COF_IDX[k][3]];
            end
            for (int j = 0; j < 3; j++)
            begin
                r1_reg[j] <= m[j];
            end
        end
        if (adv2 && v1_reg)
        begin
            for (int k = 0; k < 9; k++)
            begin
                cof_reg[k] <= p_reg[2*k] - p_reg[2*k+1];
            end
            r2_reg <= r1_reg;
        end
    end

    assign valid_out = v2_reg;
    assign cof       = cof_reg;
    assign row0      = r2_reg;

endmodule

[rtl/core/mi3_det.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_det
// Five stages: determinant partial products, terms, sum, magnitudes, and the
// singular test with the setup of the nine division lanes.
// ----------------------------------------------------------------------------
module mi3_det (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_in,
    output logic                ready_out,
    input  mi3_pkg::prod_t      cof [9],
    input  mi3_pkg::entry_t     row0 [3],
    input  logic [31:0]         limit,
    output logic                valid_out,
    input  logic                ready_in,
    output mi3_pkg::div_ctl_t   ctl,
    output mi3_pkg::div_lane_t  lane [9]
);
    import mi3_pkg::*;

    localparam int unsigned NST = 5;

    logic [NST-1:0]             v_reg;
    logic [NST-1:0]             adv;
    logic signed [PROD_W-1:0]   hi_reg [3];
    logic signed [LO_W-1:0]     lo_reg [3];
    prod_t                      ca_reg [9];
    logic signed [TERM_W-1:0]   term_reg [3];
    prod_t                      cb_reg [9];
    logic signed [DET_W-1:0]    det_reg;
    prod_t                      cc_reg [9];
    logic [MAG_W-1:0]           dmag_reg;
    logic [PROD_W-1:0]          cm_reg [9];
    logic [8:0]                 neg_reg;
    div_ctl_t                   ctl_reg;
    div_lane_t                  lane_reg [9];
    logic signed [DET_W-1:0]    det_neg;

    always_comb
    begin
        adv[NST-1] = !v_reg[NST-1] || ready_in;
        for (int s = NST - 2; s >= 0; s--)
        begin
            adv[s] = !v_reg[s] || adv[s+1];
        end
    end

    assign ready_out = adv[0];
    assign det_neg   = -det_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (adv[0])
            begin
                v_reg[0] <= valid_in;
            end
            for (int s = 1; s < NST; s++)
            begin
                if (adv[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0] && valid_in)
        begin
            for (int j = 0; j < 3; j++)
            begin
                hi_reg[j] <= row0[j] * $signed(cof[3*j][63:32]);
                lo_reg[j] <= row0[j] * $signed({1'b0, cof[3*j][31:0]});
            end
            ca_reg <= cof;
        end
        if (adv[1] && v_reg[0])
        begin
            for (int j = 0; j < 3; j++)
            begin
                term_reg[j] <= $signed({hi_reg[j], 32'b0}) + TERM_W'(lo_reg[j]);
            end
            cb_reg <= ca_reg;
        end
        if (adv[2] && v_reg[1])
        begin
            det_reg <= DET_W'(term_reg[0]) + DET_W'(term_reg[1]) + DET_W'(term_reg[2]);
            cc_reg  <= cb_reg;
        end
        if (adv[3] && v_reg[2])
        begin
            dmag_reg <= det_reg[DET_W-1] ? det_neg[MAG_W-1:0] : det_reg[MAG_W-1:0];
            for (int k = 0; k < 9; k++)
            begin
                cm_reg[k]  <= cc_reg[k][PROD_W-1] ? PROD_W'(-cc_reg[k]) : PROD_W'(cc_reg[k]);
                neg_reg[k] <= cc_reg[k][PROD_W-1] ^ det_reg[DET_W-1];
            end
        end
        if (adv[4] && v_reg[3])
        begin
            ctl_reg.dmag     <= dmag_reg;
            ctl_reg.singular <= (dmag_reg[MAG_W-1:32] == '0 && dmag_reg[31:0] < limit)
                                || dmag_reg == '0;
            for (int k = 0; k < 9; k++)
            begin
                lane_reg[k].rem    <= MAG_W'(cm_reg[k][PROD_W-1:1]);
                lane_reg[k].quo    <= '0;
                lane_reg[k].bit_in <= cm_reg[k][0];
                lane_reg[k].neg    <= neg_reg[k];
                lane_reg[k].ovf    <= MAG_W'(cm_reg[k][PROD_W-1:1]) >= dmag_reg;
            end
        end
    end

    assign valid_out = v_reg[NST-1];
    assign ctl       = ctl_reg;
    assign lane      = lane_reg;

endmodule

[rtl/core/mi3_div_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_div_step
// One restoring division step for all nine lanes: one quotient bit each.
// ----------------------------------------------------------------------------
module mi3_div_step (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_in,
    output logic                ready_out,
    input  mi3_pkg::div_ctl_t   ctl_in,
    input  mi3_pkg::div_lane_t  lane_in [9],
    output logic                valid_out,
    input  logic                ready_in,
    output mi3_pkg::div_ctl_t   ctl_out,
    output mi3_pkg::div_lane_t  lane_out [9]
);
    import mi3_pkg::*;

    logic             v_reg;
    logic             adv;
    div_ctl_t         ctl_reg;
    div_lane_t        lane_reg [9];
    div_lane_t        lane_next [9];
    logic [MAG_W:0]   trial [9];
    logic [MAG_W:0]   dm;

    assign adv       = !v_reg || ready_in;
    assign ready_out = adv;
    assign dm        = {1'b0, ctl_in.dmag};

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            trial[k]            = {lane_in[k].rem, lane_in[k].bit_in};
            lane_next[k]        = lane_in[k];
            lane_next[k].bit_in = 1'b0;
            if (trial[k] >= dm)
            begin
                lane_next[k].rem = MAG_W'(trial[k] - dm);
                lane_next[k].quo = {lane_in[k].quo[QUO_W-2:0], 1'b1};
            end
            else
            begin
                lane_next[k].rem = trial[k][MAG_W-1:0];
                lane_next[k].quo = {lane_in[k].quo[QUO_W-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && valid_in)
        begin
            ctl_reg  <= ctl_in;
            lane_reg <= lane_next;
        end
    end

    assign valid_out = v_reg;
    assign ctl_out   = ctl_reg;
    assign lane_out  = lane_reg;

endmodule

[rtl/core/mi3_out.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mi3_out
// Output register: signs and saturates the quotients, or returns the identity.
// ----------------------------------------------------------------------------
module mi3_out (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                valid_in,
    output logic                ready_out,
    input  mi3_pkg::div_ctl_t   ctl_in,
    input  mi3_pkg::div_lane_t  lane_in [9],
    mi3_out_if.source           mat_out
);
    import mi3_pkg::*;

    logic       v_reg;
    logic       adv;
    entry_t     inv_reg [9];
    logic       singular_reg;
    logic       saturated_reg;
    entry_t     inv_next [9];
    logic [8:0] sat_next;

    assign adv       = !v_reg || mat_out.ready;
    assign ready_out = adv;

    always_comb
    begin
        for (int k = 0; k < 9; k++)
        begin
            if (ctl_in.singular)
            begin
                sat_next[k] = 1'b0;
                inv_next[k] = (k % 4 == 0) ? Q16_ONE : Q16_ZERO;
            end
            else if (lane_in[k].neg)
            begin
                sat_next[k] = lane_in[k].ovf || lane_in[k].quo > QUO_NEG_MAX;
                inv_next[k] = sat_next[k] ? Q16_MIN : -$signed(lane_in[k].quo[31:0]);
            end
            else
            begin
                sat_next[k] = lane_in[k].ovf || lane_in[k].quo[32] || lane_in[k].quo[31];
                inv_next[k] = sat_next[k] ? Q16_MAX : $signed(lane_in[k].quo[31:0]);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg <= valid_in;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && valid_in)
        begin
            inv_reg       <= inv_next;
            singular_reg  <= ctl_in.singular;
            saturated_reg <= |sat_next;
        end
    end

    assign mat_out.valid     = v_reg;
    assign mat_out.inv00     = inv_reg[0];
    assign mat_out.inv01     = inv_reg[1];
    assign mat_out.inv02     = inv_reg[2];
    assign mat_out.inv10     = inv_reg[3];
    assign mat_out.inv11     = inv_reg[4];
    assign mat_out.inv12     = inv_reg[5];
    assign mat_out.inv20     = inv_reg[6];
    assign mat_out.inv21     = inv_reg[7];
    assign mat_out.inv22     = inv_reg[8];
    assign mat_out.singular  = singular_reg;
    assign mat_out.saturated = saturated_reg;

    a_sing_no_sat: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg && singular_reg |-> !saturated_reg)
        else $error("singular result also flagged saturated");

    a_sing_diag: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg && singular_reg |->
            inv_reg[0] == Q16_ONE && inv_reg[4] == Q16_ONE && inv_reg[8] == Q16_ONE)
        else $error("singular result diagonal is not one");

    a_sing_off: assert property (@(posedge clk) disable iff (!rst_n)
        v_reg && singular_reg |->
            inv_reg[1] == Q16_ZERO && inv_reg[2] == Q16_ZERO && inv_reg[3] == Q16_ZERO &&
            inv_reg[5] == Q16_ZERO && inv_reg[6] == Q16_ZERO && inv_reg[7] == Q16_ZERO)
        else $error("singular result off-diagonal is not zero");

endmodule

[rtl/core/matrix_inverse_3x3.sv]
`timescale 1ns / 1ps
// A matrix passes in turn through the cofactor, determinant, division and output registers.
// Throughput: one matrix per cycle while the output is not stalled; 2 cofactor stages, 5 determinant stages,
// 33 one-bit division stages for all nine entries and one output register.
// Reset clears every pipeline valid bit and sets limit_reg to 281474977.
// ----------------------------------------------------------------------------
// matrix_inverse_3x3
// Pipelined 3x3 inverse by the adjugate method in signed Q16.16.
// ----------------------------------------------------------------------------
module matrix_inverse_3x3 (
    input  logic    clk,
    input  logic    rst_n,
    mi3_cfg_if.sink cfg,
    mi3_in_if.sink  mat_in,
    mi3_out_if.source mat_out
);
    import mi3_pkg::*;

    logic [31:0] limit_reg;
    logic        cof_valid, cof_ready;
    prod_t       cof [9];
    entry_t      row0 [3];
    logic        sv    [DIV_STEPS+1];
    logic        sr    [DIV_STEPS+1];
    div_ctl_t    sctl  [DIV_STEPS+1];
    div_lane_t   slane [DIV_STEPS+1][9];

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limit_reg <= LIMIT_RESET;
        end
        else if (cfg.valid)
        begin
            limit_reg <= cfg.data;
        end
    end

    mi3_cof u_cof (
        .clk       (clk),
        .rst_n     (rst_n),
        .mat_in    (mat_in),
        .valid_out (cof_valid),
        .ready_in  (cof_ready),
        .cof       (cof),
        .row0      (row0)
    );

    mi3_det u_det (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (cof_valid),
        .ready_out (cof_ready),
        .cof       (cof),
        .row0      (row0),
        .limit     (limit_reg),
        .valid_out (sv[0]),
        .ready_in  (sr[0]),
        .ctl       (sctl[0]),
        .lane      (slane[0])
    );

    for (genvar i = 0; i < DIV_STEPS; i++)
    begin : g_div
        mi3_div_step u_step (
            .clk       (clk),
            .rst_n     (rst_n),
            .valid_in  (sv[i]),
            .ready_out (sr[i]),
            .ctl_in    (sctl[i]),
            .lane_in   (slane[i]),
            .valid_out (sv[i+1]),
            .ready_in  (sr[i+1]),
            .ctl_out   (sctl[i+1]),
            .lane_out  (slane[i+1])
        );
    end

    mi3_out u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .valid_in  (sv[DIV_STEPS]),
        .ready_out (sr[DIV_STEPS]),
        .ctl_in    (sctl[DIV_STEPS]),
        .lane_in   (slane[DIV_STEPS]),
        .mat_out   (mat_out)
    );

endmodule
